### hdl/lsfp_pkg.sv
// ----------------------------------------------------------------------------
// lsfp_pkg
// Shared types and constants of the line sensor frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package lsfp_pkg;

   localparam int CHANNELS    = 8;
   localparam int FRAME_LIMIT = 96;
   localparam int COUNT_W     = 7;
   localparam int DIGIT_W     = 4;
   localparam int AGE_W       = 16;

   localparam logic [COUNT_W-1:0] COUNT_LAST = COUNT_W'(FRAME_LIMIT - 1);
   localparam logic [DIGIT_W-1:0] DIGIT_ALL  = DIGIT_W'(CHANNELS);
   localparam logic [AGE_W-1:0]   AGE_MAX    = {AGE_W{1'b1}};

   localparam logic [AGE_W-1:0] PERIOD_RESET  = 16'd500;
   localparam logic [AGE_W-1:0] TIMEOUT_RESET = 16'd300;

   localparam logic [7:0] CH_START = 8'h24;  // '$'
   localparam logic [7:0] CH_ID    = 8'h44;  // 'D'
   localparam logic [7:0] CH_SEP   = 8'h3A;  // ':'
   localparam logic [7:0] CH_END   = 8'h23;  // '#'
   localparam logic [7:0] CH_ABORT = 8'h21;  // '!'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [2:0] ADDR_PERIOD  = 3'h0;
   localparam logic [2:0] ADDR_TIMEOUT = 3'h4;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      PH_EXPECT_ID = 3'd0,
      PH_SEEK      = 3'd1,
      PH_DIGIT     = 3'd2,
      PH_DONE      = 3'd3,
      PH_FAIL      = 3'd4
   } phase_type;

   typedef struct packed {
      logic [AGE_W-1:0] period;
      logic [AGE_W-1:0] timeout;
   } cfg_type;

   typedef struct packed {
      logic commit;
      logic have_next;
   } commit_type;

endpackage

`default_nettype wire

### hdl/lsfp_req_if.sv
// ----------------------------------------------------------------------------
// lsfp_req_if
// Input channel: serial bytes and millisecond ticks.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfp_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] rx_data;

   modport source (output valid, output opcode, output rx_data, input ready);
   modport sink   (input valid, input opcode, input rx_data, output ready);
endinterface

`default_nettype wire

### hdl/lsfp_rsp_if.sv
// ----------------------------------------------------------------------------
// lsfp_rsp_if
// Result channel: committed mask and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_mask;
   logic       mask_valid;
   logic       sensor_online;
   logic       send_request;
   logic       frame_accepted;

   modport source (output valid, output line_mask, output mask_valid,
                   output sensor_online, output send_request,
                   output frame_accepted, input ready);
   modport sink   (input valid, input line_mask, input mask_valid,
                   input sensor_online, input send_request,
                   input frame_accepted, output ready);
endinterface

`default_nettype wire

### hdl/lsfp_csr.sv
// ----------------------------------------------------------------------------
// lsfp_csr
// APB register file: request period and online timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfp_csr
   import lsfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready,
   output cfg_type          cfg
);

   logic [AGE_W-1:0] period_ff, period_in;
   logic [AGE_W-1:0] timeout_ff, timeout_in;
   logic             wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // word decode on address bit 2
   always_comb begin
      period_in  = period_ff;
      timeout_in = timeout_ff;
      if (wr_en) begin
         if (paddr[2] == ADDR_TIMEOUT[2]) begin
            timeout_in = pwdata[AGE_W-1:0];
         end else begin
            period_in = pwdata[AGE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff  <= PERIOD_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         period_ff  <= period_in;
         timeout_ff <= timeout_in;
      end
   end

   assign prdata = (paddr[2] == ADDR_TIMEOUT[2]) ? {16'd0, timeout_ff}
                                                 : {16'd0, period_ff};

   assign cfg.period  = period_ff;
   assign cfg.timeout = timeout_ff;

endmodule

`default_nettype wire

### hdl/lsfp_parser.sv
// ----------------------------------------------------------------------------
// lsfp_parser
// Byte-at-a-time frame parser and committed mask store.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfp_parser
   import lsfp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       fire,
   input  wire logic       opcode,
   input  wire logic [7:0] rx_data,
   output logic      [7:0] mask_next,
   output commit_type      link
);

   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   phase_type          phase_ff, phase_in;
   logic [DIGIT_W-1:0] digits_ff, digits_in;
   logic [7:0]         pending_ff, pending_in;
   logic [7:0]         committed_ff, committed_in;
   logic               have_ff, have_in;
   logic               commit;

   always_comb begin
      in_frame_in  = in_frame_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      digits_in    = digits_ff;
      pending_in   = pending_ff;
      committed_in = committed_ff;
      have_in      = have_ff;
      commit       = 1'b0;

      if (opcode == OP_BYTE) begin
         if (rx_data == CH_START) begin
            in_frame_in = 1'b1;
            count_in    = COUNT_W'(1);
            phase_in    = PH_EXPECT_ID;
            digits_in   = '0;
            pending_in  = '0;
         end else if (in_frame_ff) begin
            if (count_ff >= COUNT_LAST) begin
               // overlong frame: this byte is dropped too
               in_frame_in = 1'b0;
               count_in    = '0;
            end else if (rx_data == CH_ABORT) begin
               in_frame_in = 1'b0;
               count_in    = '0;
            end else if (rx_data == CH_END) begin
               in_frame_in = 1'b0;
               count_in    = '0;
               if (phase_ff == PH_DONE) begin
                  committed_in = pending_ff;
                  have_in      = 1'b1;
                  commit       = 1'b1;
               end
            end else begin
               count_in = count_ff + COUNT_W'(1);
               unique case (phase_ff)
                  PH_EXPECT_ID: begin
                     phase_in = (rx_data == CH_ID) ? PH_SEEK : PH_FAIL;
                  end
                  PH_SEEK: begin
                     if (rx_data == CH_SEP) begin
                        phase_in = PH_DIGIT;
                     end else if (rx_data == CH_NUL) begin
                        phase_in = PH_FAIL;
                     end
                  end
                  PH_DIGIT: begin
                     if (rx_data == CH_ZERO || rx_data == CH_ONE) begin
                        if (rx_data == CH_ZERO && digits_ff < DIGIT_W'(8)) begin
                           pending_in[digits_ff[2:0]] = 1'b1;
                        end
                        digits_in = digits_ff + DIGIT_W'(1);
                        phase_in  = (digits_in >= DIGIT_ALL) ? PH_DONE : PH_SEEK;
                     end else begin
                        phase_in = PH_FAIL;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         phase_ff     <= PH_EXPECT_ID;
         digits_ff    <= '0;
         pending_ff   <= '0;
         committed_ff <= '0;
         have_ff      <= 1'b0;
      end else if (fire) begin
         in_frame_ff  <= in_frame_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         digits_ff    <= digits_in;
         pending_ff   <= pending_in;
         committed_ff <= committed_in;
         have_ff      <= have_in;
      end
   end

   assign mask_next      = committed_in;
   assign link.commit    = commit;
   assign link.have_next = have_in;

endmodule

`default_nettype wire

### hdl/lsfp_ager.sv
// ----------------------------------------------------------------------------
// lsfp_ager
// Millisecond age counters, online status and stream request pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module lsfp_ager
   import lsfp_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   fire,
   input  wire logic   opcode,
   input  commit_type  link,
   input  cfg_type     cfg,
   output logic        online,
   output logic        send_request
);

   logic [AGE_W-1:0] update_age_ff, update_age_in;
   logic [AGE_W-1:0] request_age_ff, request_age_in;
   logic [AGE_W-1:0] update_inc, request_inc;

   assign update_inc  = (update_age_ff == AGE_MAX) ? update_age_ff
                                                   : update_age_ff + AGE_W'(1);
   assign request_inc = (request_age_ff == AGE_MAX) ? request_age_ff
                                                    : request_age_ff + AGE_W'(1);

   always_comb begin
      update_age_in  = update_age_ff;
      request_age_in = request_age_ff;
      send_request   = 1'b0;
      if (opcode == OP_TICK) begin
         update_age_in  = update_inc;
         request_age_in = request_inc;
         if (request_inc >= cfg.period &&
             (!link.have_next || update_inc > cfg.timeout)) begin
            send_request   = 1'b1;
            request_age_in = '0;
         end
      end else if (link.commit) begin
         update_age_in = '0;
      end
   end

   assign online = link.have_next && (update_age_in <= cfg.timeout);

   always_ff @(posedge clock) begin
      if (reset) begin
         update_age_ff  <= '0;
         request_age_ff <= '0;
      end else if (fire) begin
         update_age_ff  <= update_age_in;
         request_age_ff <= request_age_in;
      end
   end

endmodule

`default_nettype wire

### hdl/line_sensor_frame_parser.sv
// ----------------------------------------------------------------------------
// line_sensor_frame_parser
// Parses '$D:...#' sensor frames byte by byte and ages them on ms ticks.
// ----------------------------------------------------------------------------
// datapath: an accepted item passes the input register, then the result
//   register; a stalled result channel holds both
// throughput: one item per cycle while results are taken, set by the input
//   register feeding the combinational parse and age update
// reset: synchronous; clears parser state, ages, committed mask and valid flag,
//   and loads the request period (500) and online timeout (300)
`default_nettype none

module line_sensor_frame_parser
   import lsfp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   lsfp_req_if.sink         req_ch,
   lsfp_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg;
   commit_type link;

   logic       in_valid_ff;
   logic       in_opcode_ff;
   logic [7:0] in_data_ff;

   logic       out_valid_ff;
   logic [7:0] mask_ff;
   logic       have_ff;
   logic       online_ff;
   logic       request_ff;
   logic       accepted_ff;

   logic       advance;
   logic       fire;
   logic [7:0] mask_next;
   logic       online;
   logic       send_request;

   assign advance      = !out_valid_ff || rsp_ch.ready;
   assign fire         = in_valid_ff && advance;
   assign req_ch.ready = !in_valid_ff || advance;

   lsfp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   lsfp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .opcode    (in_opcode_ff),
      .rx_data   (in_data_ff),
      .mask_next (mask_next),
      .link      (link)
   );

   lsfp_ager u_ager (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .opcode       (in_opcode_ff),
      .link         (link),
      .cfg          (cfg),
      .online       (online),
      .send_request (send_request)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_opcode_ff <= req_ch.opcode;
         in_data_ff   <= req_ch.rx_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mask_ff     <= mask_next;
         have_ff     <= link.have_next;
         online_ff   <= online;
         request_ff  <= send_request;
         accepted_ff <= link.commit;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.line_mask      = mask_ff;
   assign rsp_ch.mask_valid     = have_ff;
   assign rsp_ch.sensor_online  = online_ff;
   assign rsp_ch.send_request   = request_ff;
   assign rsp_ch.frame_accepted = accepted_ff;

endmodule

`default_nettype wire

### verif/tb_line_sensor_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_sensor_frame_parser
// Self-checking bench for the line sensor frame parser. A short table of
// bytes and ticks opens the run, then random frames run under several timer
// settings: good frames, broken ones, tick runs and stray bytes. Each result is
// compared with the table's status on typed rows, else with a predictor.
// ----------------------------------------------------------------------------

module tb_line_sensor_frame_parser;
   import lsfp_pkg::*;

   typedef struct packed {
      logic [7:0] line_mask;
      logic       mask_valid;
      logic       sensor_online;
      logic       send_request;
      logic       frame_accepted;
   } line_status_type;

   typedef struct packed {
      opcode_type      op;
      logic [7:0]      data;
      logic            typed;
      line_status_type status;
   } stim_row_type;

   typedef enum int {
      SEQ_GOOD,
      SEQ_ABORT,
      SEQ_BAD_ID,
      SEQ_NUL_SEEK,
      SEQ_BAD_DIGIT,
      SEQ_RESTART,
      SEQ_SHORT,
      SEQ_LONG,
      SEQ_TICKS,
      SEQ_NOISE
   } seq_kind_type;

   localparam line_status_type IDLE_STATUS = '0;
   localparam line_status_type FULL_STATUS = '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b0};
   localparam line_status_type COMMIT_STATUS = '{8'hFF, 1'b1, 1'b1, 1'b0, 1'b1};
   localparam int PHASE_ITEMS = 95;
   localparam int ROWS = 25;

   // frame with every digit '0' commits the full mask
   localparam stim_row_type DIRECTED [ROWS] = '{
      '{OP_TICK, 8'hFF, 1'b1, IDLE_STATUS},
      '{OP_BYTE, CH_NUL, 1'b1, IDLE_STATUS},
      '{OP_BYTE, 8'hFF, 1'b1, IDLE_STATUS},
      '{OP_BYTE, CH_END, 1'b1, IDLE_STATUS},
      '{OP_BYTE, CH_START, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_ID, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_SEP, 1'b0, IDLE_STATUS}, '{OP_BYTE, CH_ZERO, 1'b0, IDLE_STATUS},
      '{OP_BYTE, CH_END, 1'b1, COMMIT_STATUS},
      '{OP_TICK, 8'h00, 1'b1, FULL_STATUS},
      '{OP_BYTE, CH_ID, 1'b1, FULL_STATUS}
   };

   logic clock = 1'b0;
   logic reset;

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lsfp_req_if req_if ();
   lsfp_rsp_if rsp_if ();

   line_sensor_frame_parser dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   logic [AGE_W-1:0]   cfg_period;
   logic [AGE_W-1:0]   cfg_timeout;
   logic               frm_open;
   logic [COUNT_W-1:0] frm_count;
   phase_type          frm_phase;
   logic [DIGIT_W-1:0] frm_digits;
   logic [7:0]         frm_pending;
   logic [7:0]         mask_q;
   logic               have_mask_q;
   logic [AGE_W-1:0]   update_age_q;
   logic [AGE_W-1:0]   request_age_q;

   line_status_type status_expected [$];
   line_status_type seen_status;
   line_status_type want_status;
   int mismatches = 0;
   int items_sent;
   int burst_left = 0;

   logic [7:0] frame_bytes [$];
   int         digit_pos [$];

   function automatic line_status_type parse_and_age(input opcode_type op, input logic [7:0] b);
      line_status_type s;
      logic pulse;
      logic commit;
      pulse = 1'b0;
      commit = 1'b0;
      if (op == OP_TICK) begin
         if (update_age_q != AGE_MAX) update_age_q = update_age_q + 1'b1;
         if (request_age_q != AGE_MAX) request_age_q = request_age_q + 1'b1;
         if (request_age_q >= cfg_period && (!have_mask_q || update_age_q > cfg_timeout)) begin
            request_age_q = '0;
            pulse = 1'b1;
         end
      end else if (b == CH_START) begin
         frm_open = 1'b1;
         frm_count = COUNT_W'(1);
         frm_phase = PH_EXPECT_ID;
         frm_digits = '0;
         frm_pending = '0;
      end else if (frm_open) begin
         if (frm_count >= COUNT_LAST) begin
            // too long: this byte is dropped unless it is a start byte
            frm_open = 1'b0;
            frm_count = '0;
         end else begin
            frm_count = frm_count + 1'b1;
            if (b == CH_ABORT) begin
               frm_open = 1'b0;
               frm_count = '0;
            end else if (b == CH_END) begin
               frm_open = 1'b0;
               frm_count = '0;
               if (frm_phase == PH_DONE) begin
                  mask_q = frm_pending;
                  have_mask_q = 1'b1;
                  update_age_q = '0;
                  commit = 1'b1;
               end
            end else begin
               case (frm_phase)
                  PH_EXPECT_ID: begin
                     if (b == CH_ID) frm_phase = PH_SEEK;
                     else frm_phase = PH_FAIL;
                  end
                  PH_SEEK: begin
                     if (b == CH_SEP) frm_phase = PH_DIGIT;
                     else if (b == CH_NUL) frm_phase = PH_FAIL;
                  end
                  PH_DIGIT: begin
                     if (b == CH_ZERO || b == CH_ONE) begin
                        if (b == CH_ZERO) frm_pending[frm_digits[2:0]] = 1'b1;
                        frm_digits = frm_digits + 1'b1;
                        if (frm_digits >= DIGIT_ALL) frm_phase = PH_DONE;
                        else frm_phase = PH_SEEK;
                     end else begin
                        frm_phase = PH_FAIL;
                     end
                  end
                  default: ;
               endcase
            end
         end
      end
      s.line_mask = mask_q;
      s.mask_valid = have_mask_q;
      s.sensor_online = have_mask_q && (update_age_q <= cfg_timeout);
      s.send_request = pulse;
      s.frame_accepted = commit;
      return s;
   endfunction

   // filler that the parser skips while seeking a separator
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CH_START || b == CH_END || b == CH_ABORT || b == CH_SEP ||
                 b == CH_NUL);
      return b;
   endfunction

   // anything that does not end or restart a frame
   function automatic logic [7:0] trail_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CH_START || b == CH_END || b == CH_ABORT);
      return b;
   endfunction

   function automatic void build_good_frame(input int trail);
      frame_bytes.delete();
      digit_pos.delete();
      frame_bytes.push_back(CH_START);
      frame_bytes.push_back(CH_ID);
      for (int i = 0; i < CHANNELS; i++) begin
         repeat ($urandom_range(0, 2)) frame_bytes.push_back(plain_byte());
         frame_bytes.push_back(CH_SEP);
         digit_pos.push_back(frame_bytes.size());
         frame_bytes.push_back($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
      end
      repeat (trail) frame_bytes.push_back(trail_byte());
      frame_bytes.push_back(CH_END);
   endfunction

   task automatic send_item(input opcode_type op, input logic [7:0] data, input logic typed,
                            input line_status_type typed_status);
      line_status_type predicted;
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.rx_data <= data;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = parse_and_age(op, data);
      status_expected.push_back(typed ? typed_status : predicted);
      if (burst_left == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (status_expected.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [AGE_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= {16'h0000, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == ADDR_PERIOD) cfg_period = value;
      else if (addr == ADDR_TIMEOUT) cfg_timeout = value;
      @(posedge clock);
   endtask

   task automatic reconfigure(input logic [AGE_W-1:0] period, input logic [AGE_W-1:0] timeout);
      settle_block();
      csr_write(ADDR_PERIOD, period);
      csr_write(ADDR_TIMEOUT, timeout);
   endtask

   task automatic send_sequence();
      seq_kind_type kind;
      int           roll;
      int           p;
      int           j;
      int           n;
      logic [7:0]   b;
      logic [7:0]   spare [$];
      roll = $urandom_range(0, 99);
      if (roll < 40) kind = SEQ_GOOD;
      else if (roll < 46) kind = SEQ_ABORT;
      else if (roll < 51) kind = SEQ_BAD_ID;
      else if (roll < 56) kind = SEQ_NUL_SEEK;
      else if (roll < 64) kind = SEQ_BAD_DIGIT;
      else if (roll < 69) kind = SEQ_RESTART;
      else if (roll < 74) kind = SEQ_SHORT;
      else if (roll < 78) kind = SEQ_LONG;
      else if (roll < 95) kind = SEQ_TICKS;
      else kind = SEQ_NOISE;

      case (kind)
         SEQ_TICKS: begin
            n = $urandom_range(1, 30);
            repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, IDLE_STATUS);
            items_sent += n;
         end
         SEQ_NOISE: begin
            // bytes outside a frame
            n = $urandom_range(1, 4);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               if (b == CH_START) b = CH_NUL;
               send_item(OP_BYTE, b, 1'b0, IDLE_STATUS);
            end
            items_sent += n;
         end
         default: begin
            // long trailers straddle the length limit
            build_good_frame(kind == SEQ_LONG ? $urandom_range(60, 80) : $urandom_range(0, 3));
            case (kind)
               SEQ_ABORT: begin
                  p = $urandom_range(1, frame_bytes.size() - 1);
                  frame_bytes.insert(p, CH_ABORT);
               end
               SEQ_BAD_ID: begin
                  b = trail_byte();
                  if (b == CH_ID) b = CH_NUL;
                  frame_bytes[1] = b;
               end
               SEQ_NUL_SEEK: begin
                  j = $urandom_range(0, CHANNELS - 1);
                  frame_bytes.insert(digit_pos[j] - 1, CH_NUL);
               end
               SEQ_BAD_DIGIT: begin
                  j = $urandom_range(0, CHANNELS - 1);
                  case ($urandom_range(0, 3))
                     0: b = CH_NUL;
                     1: b = CH_SEP;
                     2: b = CH_END;
                     default: begin
                        b = plain_byte();
                        if (b == CH_ZERO || b == CH_ONE) b = 8'h32;
                     end
                  endcase
                  frame_bytes[digit_pos[j]] = b;
               end
               SEQ_RESTART: begin
                  // partial frame cut short by a fresh start byte
                  spare = frame_bytes;
                  p = $urandom_range(1, frame_bytes.size() - 2);
                  while (frame_bytes.size() > p) void'(frame_bytes.pop_back());
                  foreach (spare[k]) frame_bytes.push_back(spare[k]);
               end
               SEQ_SHORT: begin
                  j = $urandom_range(0, CHANNELS - 2);
                  while (frame_bytes.size() > digit_pos[j] + 1) void'(frame_bytes.pop_back());
                  frame_bytes.push_back(CH_END);
               end
               default: ;
            endcase
            foreach (frame_bytes[k]) begin
               if ($urandom_range(0, 9) == 0) begin
                  send_item(OP_TICK, 8'($urandom_range(0, 255)), 1'b0, IDLE_STATUS);
                  items_sent++;
               end
               send_item(OP_BYTE, frame_bytes[k], 1'b0, IDLE_STATUS);
            end
            items_sent += frame_bytes.size();
         end
      endcase
   endtask

   task automatic random_phase();
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) send_sequence();
   endtask

   // result receiver: quiet stretches and stretches of random stalls
   initial begin
      int  hold;
      bit  stalling;
      hold = 0;
      stalling = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold == 0) begin
            stalling = ($urandom_range(0, 2) == 0);
            hold = $urandom_range(4, 40);
         end
         hold--;
         rsp_if.ready <= stalling ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         seen_status = '{rsp_if.line_mask, rsp_if.mask_valid, rsp_if.sensor_online,
                         rsp_if.send_request, rsp_if.frame_accepted};
         if (status_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result: mask %h valid %b online %b req %b acc %b",
                        $realtime, seen_status.line_mask, seen_status.mask_valid,
                        seen_status.sensor_online, seen_status.send_request,
                        seen_status.frame_accepted);
         end else begin
            want_status = status_expected.pop_front();
            if (seen_status !== want_status) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $write("%0t: mismatch exp/got: mask %h/%h valid %b/%b ", $realtime,
                         want_status.line_mask, seen_status.line_mask,
                         want_status.mask_valid, seen_status.mask_valid);
                  $display("online %b/%b req %b/%b acc %b/%b",
                           want_status.sensor_online, seen_status.sensor_online,
                           want_status.send_request, seen_status.send_request,
                           want_status.frame_accepted, seen_status.frame_accepted);
               end
            end
         end
      end
   end

   initial begin
      #25_000_000;
      $display("line_sensor_frame_parser regression: fail");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.opcode = OP_BYTE;
      req_if.rx_data = 8'h00;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = ADDR_PERIOD;
      csr_pwdata = '0;
      cfg_period = PERIOD_RESET;
      cfg_timeout = TIMEOUT_RESET;
      frm_open = 1'b0;
      frm_count = '0;
      frm_phase = PH_EXPECT_ID;
      frm_digits = '0;
      frm_pending = '0;
      mask_q = '0;
      have_mask_q = 1'b0;
      update_age_q = '0;
      request_age_q = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < ROWS; i++)
         send_item(DIRECTED[i].op, DIRECTED[i].data, DIRECTED[i].typed, DIRECTED[i].status);

      random_phase();
      reconfigure(16'd1, 16'd1);
      random_phase();
      reconfigure(16'd0, 16'd0);
      random_phase();
      reconfigure(AGE_W'($urandom_range(2, 40)), AGE_W'($urandom_range(1, 30)));
      random_phase();

      reconfigure(16'd3, AGE_MAX);
      random_phase();

      settle_block();
      repeat (6) @(posedge clock);
      if (mismatches == 0 && status_expected.size() == 0)
         $display("line_sensor_frame_parser regression: pass");
      else
         $display("line_sensor_frame_parser regression: fail");
      $finish;
   end

endmodule
